>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked concurrent assertions with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define U2D_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define U2D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/u2d_pkg.sv
// ----------------------------------------------------------------------------
// u2d_pkg
// Shared widths, codes, types and helper functions for the decimal converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u2d_pkg;

    localparam int VALUE_W    = 32;
    localparam int SPACE_W    = 8;
    localparam int BYTE_W     = 8;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int CNT_W      = 4;
    // Double-dabble shifts done per pipeline stage.
    localparam int DD_STEPS   = 8;
    localparam int DD_STAGES  = VALUE_W / DD_STEPS;

    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] NUL_BYTE   = 8'h00;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NOSPACE = 1'b1;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] t_bcd;

    typedef struct packed {
        t_bcd               bcd;
        logic [VALUE_W-1:0] bin;
        logic [SPACE_W-1:0] space;
        logic               add_delim;
        logic [BYTE_W-1:0]  delim;
    } t_dd;

    // One double-dabble step: add 3 to every digit >= 5, then shift left.
    function automatic t_dd dd_step(input t_dd d);
        t_dd  r;
        t_bcd adj;
        r = d;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            adj[i] = (d.bcd[i] >= 4'd5) ? d.bcd[i] + 4'd3 : d.bcd[i];
        end
        {r.bcd, r.bin} = {adj, d.bin} << 1;
        return r;
    endfunction

    // Number of significant digits, at least one.
    function automatic logic [CNT_W-1:0] digit_count(input t_bcd b);
        logic [CNT_W-1:0] n;
        n = CNT_W'(1);
        for (int i = 1; i < NUM_DIGITS; i++) begin
            if (b[i] != '0) begin
                n = CNT_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

>>> sv/u2d_stream_if.sv
// ----------------------------------------------------------------------------
// u2d_stream_if
// Valid/ready channels for the converter: request in, byte stream out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface u2d_in_if;
    import u2d_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [SPACE_W-1:0] space_bytes;
    logic               add_delimiter;
    logic [BYTE_W-1:0]  delimiter;

    modport source (output valid, value, space_bytes, add_delimiter, delimiter,
                    input ready);
    modport sink   (input valid, value, space_bytes, add_delimiter, delimiter,
                    output ready);
endinterface

interface u2d_out_if;
    import u2d_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              is_last;
    logic              status;

    modport source (output valid, out_byte, is_last, status, input ready);
    modport sink   (input valid, out_byte, is_last, status, output ready);
endinterface

`default_nettype wire

>>> sv/u2d_dd_stage.sv
// ----------------------------------------------------------------------------
// u2d_dd_stage
// One pipeline stage of the binary-to-BCD conversion, a fixed number of
// double-dabble shifts between registers, with valid/ready flow control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u2d_dd_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  u2d_pkg::t_dd  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output u2d_pkg::t_dd  o_data
);
    import u2d_pkg::*;

    logic r_valid;
    t_dd  r_data;
    t_dd  n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data = i_data;
        for (int s = 0; s < DD_STEPS; s++) begin
            n_data = dd_step(n_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/u2d_ser.sv
// ----------------------------------------------------------------------------
// u2d_ser
// Byte serializer: sizes the digit string, checks buffer space and sends
// digits then the terminator (or one error byte) through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u2d_ser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  u2d_pkg::t_dd    i_data,
    u2d_out_if.source       o_out
);
    import u2d_pkg::*;

    // Item being sent
    logic             r_busy;
    logic             r_err;
    logic             r_on_term;
    logic [CNT_W-1:0] r_idx;
    t_bcd             r_bcd;
    logic [BYTE_W-1:0] r_term;

    // Output register
    logic              r_ovalid;
    logic [BYTE_W-1:0] r_obyte;
    logic              r_olast;
    logic              r_ostat;

    logic              load;
    logic              step;
    logic              done;
    logic              take;
    logic [CNT_W-1:0]  cnt;
    logic              no_space;
    logic [BYTE_W-1:0] n_obyte;
    logic              n_olast;
    logic              n_ostat;

    assign load     = !r_ovalid || o_out.ready;
    assign step     = load && r_busy;
    assign done     = r_err || r_on_term;
    assign o_ready  = !r_busy || (step && done);
    assign take     = i_valid && o_ready;
    assign cnt      = digit_count(i_data.bcd);
    // Need cnt digits plus the terminator.
    assign no_space = i_data.space <= {{(SPACE_W-CNT_W){1'b0}}, cnt};

    always_comb begin
        if (r_err) begin
            n_obyte = NUL_BYTE;
            n_olast = 1'b1;
            n_ostat = STATUS_NOSPACE;
        end else if (r_on_term) begin
            n_obyte = r_term;
            n_olast = 1'b1;
            n_ostat = STATUS_OK;
        end else begin
            n_obyte = ASCII_ZERO | {{(BYTE_W-DIGIT_W){1'b0}}, r_bcd[r_idx]};
            n_olast = 1'b0;
            n_ostat = STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_err     <= 1'b0;
            r_on_term <= 1'b0;
            r_idx     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (load) begin
                r_ovalid <= r_busy;
            end
            if (take) begin
                r_busy    <= 1'b1;
                r_err     <= no_space;
                r_on_term <= 1'b0;
                r_idx     <= cnt - CNT_W'(1);
            end else if (step && done) begin
                r_busy <= 1'b0;
            end else if (step) begin
                if (r_idx == '0) begin
                    r_on_term <= 1'b1;
                end else begin
                    r_idx <= r_idx - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_bcd  <= i_data.bcd;
            r_term <= i_data.add_delim ? i_data.delim : NUL_BYTE;
        end
        if (step) begin
            r_obyte <= n_obyte;
            r_olast <= n_olast;
            r_ostat <= n_ostat;
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.out_byte = r_obyte;
    assign o_out.is_last  = r_olast;
    assign o_out.status   = r_ostat;

endmodule

`default_nettype wire

>>> sv/uint32_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// uint32_to_decimal_ascii
// Unsigned 32-bit to decimal ASCII string converter with buffer space check.
// ----------------------------------------------------------------------------
// A request carries a 32-bit value, the free buffer space and an optional
// delimiter; the block answers with the decimal digits, most significant
// first, one byte per transaction, then a terminator byte (NUL or the
// delimiter) flagged is_last. If the space is not more than the digit count,
// a single byte 0 with is_last and status set is sent instead. The binary to
// BCD conversion runs in four register stages of eight double-dabble shifts
// each, so requests enter back to back while the pipeline has room; the
// byte serializer then sends n+1 bytes (2 to 11) per request, or one on
// error, one byte per cycle while the output is ready, and that sets the
// sustained rate.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module uint32_to_decimal_ascii (
    input  logic       i_clk,
    input  logic       i_rst_n,
    u2d_in_if.sink     i_in,
    u2d_out_if.source  o_out
);
    import u2d_pkg::*;

    t_dd  s_data  [0:DD_STAGES];
    logic s_valid [0:DD_STAGES];
    logic s_ready [0:DD_STAGES];

    assign s_data[0].bcd       = '0;
    assign s_data[0].bin       = i_in.value;
    assign s_data[0].space     = i_in.space_bytes;
    assign s_data[0].add_delim = i_in.add_delimiter;
    assign s_data[0].delim     = i_in.delimiter;
    assign s_valid[0]          = i_in.valid;
    assign i_in.ready          = s_ready[0];

    for (genvar g = 0; g < DD_STAGES; g++) begin : g_dd
        u2d_dd_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[g]),
            .o_ready (s_ready[g]),
            .i_data  (s_data[g]),
            .o_valid (s_valid[g+1]),
            .i_ready (s_ready[g+1]),
            .o_data  (s_data[g+1])
        );
    end

    u2d_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid[DD_STAGES]),
        .o_ready (s_ready[DD_STAGES]),
        .i_data  (s_data[DD_STAGES]),
        .o_out   (o_out)
    );

    // Error result is a lone zero byte that closes the item.
    `U2D_ASSERT_NOW(a_err_form, i_clk, i_rst_n, o_out.valid && o_out.status == STATUS_NOSPACE, o_out.is_last && o_out.out_byte == NUL_BYTE, "error result malformed")

    // Anything before the terminator is an ASCII digit with ok status.
    `U2D_ASSERT_NOW(a_digit_form, i_clk, i_rst_n, o_out.valid && !o_out.is_last, o_out.status == STATUS_OK && o_out.out_byte >= ASCII_ZERO && o_out.out_byte <= ASCII_ZERO + 8'd9, "non-terminal byte is not a digit")

    // Bytes of one item leave without gaps.
    `U2D_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n, o_out.valid && o_out.ready && !o_out.is_last, o_out.valid, "gap inside a digit string")

endmodule

`default_nettype wire

>>> tb/sv/decimal_text_monitor.sv
// ----------------------------------------------------------------------------
// decimal_text_monitor
// Watches the request and byte channels of the decimal converter, predicts the
// ASCII text (or the no-space error) of every accepted request and compares
// each accepted output transaction, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_text_monitor (
    input  logic  i_clk,
    input  logic  i_rst_n,
    u2d_in_if     i_req,
    u2d_out_if    i_txt,
    output int    o_fail_count,
    output int    o_pending
);
    import u2d_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_last;
        logic              status;
    } t_text_byte;

    t_text_byte expected_text_q[$];
    int         fail_count = 0;

    function automatic void push_byte(input logic [BYTE_W-1:0] b, input logic last,
                                      input logic st);
        t_text_byte e;
        e.out_byte = b;
        e.is_last  = last;
        e.status   = st;
        expected_text_q.push_back(e);
    endfunction

    // Digits are peeled off least significant first, then queued in reverse.
    function automatic void predict_text(input logic [VALUE_W-1:0] value,
                                         input logic [SPACE_W-1:0] space,
                                         input logic add_delim,
                                         input logic [BYTE_W-1:0] delim);
        logic [BYTE_W-1:0]  digit_chars [NUM_DIGITS];
        logic [VALUE_W-1:0] rest;
        int                 n;
        rest = value;
        n    = 0;
        do begin
            digit_chars[n] = ASCII_ZERO + BYTE_W'(rest % 10);
            rest = rest / 10;
            n++;
        end while (rest != 0);

        if (int'(space) <= n) begin
            push_byte(NUL_BYTE, 1'b1, STATUS_NOSPACE);
        end else begin
            for (int k = n - 1; k >= 0; k--) begin
                push_byte(digit_chars[k], 1'b0, STATUS_OK);
            end
            push_byte(add_delim ? delim : NUL_BYTE, 1'b1, STATUS_OK);
        end
    endfunction

    function automatic void note_failure();
        fail_count++;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            note_failure();
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_byte e;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready) begin
                predict_text(i_req.value, i_req.space_bytes, i_req.add_delimiter,
                             i_req.delimiter);
            end
            if (i_txt.valid && i_txt.ready) begin
                if (expected_text_q.size() == 0) begin
                    note_failure();
                    $error("unexpected transaction: out_byte %0h is_last %0b status %0b",
                           i_txt.out_byte, i_txt.is_last, i_txt.status);
                end else begin
                    e = expected_text_q.pop_front();
                    check_field("out_byte", 32'(e.out_byte), 32'(i_txt.out_byte));
                    check_field("is_last", 32'(e.is_last), 32'(i_txt.is_last));
                    check_field("status", 32'(e.status), 32'(i_txt.status));
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_text_q.size();
    end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives requests into the decimal converter with random gaps and random
// output back-pressure: a directed set of digit-count boundaries, space
// limits and terminator choices, then random requests mostly shaped around
// the space limit. The monitor does the checking; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import u2d_pkg::*;

    localparam int NUM_RANDOM  = 460;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 24;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending_count;
    int   cycle_count = 0;
    int   ready_run   = 0;
    int   burst_left  = 0;

    u2d_in_if  req_ch ();
    u2d_out_if txt_ch ();

    uint32_to_decimal_ascii dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (txt_ch)
    );

    decimal_text_monitor text_mon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_txt        (txt_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Output back-pressure: mostly short stalls, some long ones, and
    // stretches with ready held high.
    always @(posedge i_clk) begin
        int pick;
        if (ready_run > 0) begin
            ready_run <= ready_run - 1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                txt_ch.ready <= 1'b1;
                ready_run    <= $urandom_range(0, 6);
            end else if (pick < 88) begin
                txt_ch.ready <= 1'b0;
                ready_run    <= $urandom_range(0, 3);
            end else if (pick < 95) begin
                txt_ch.ready <= 1'b1;
                ready_run    <= $urandom_range(20, 80);
            end else begin
                txt_ch.ready <= 1'b0;
                ready_run    <= $urandom_range(10, 40);
            end
        end
    end

    function automatic int next_gap();
        int pick;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            burst_left = $urandom_range(10, 30);
            return 0;
        end
        if (pick < 60) return 0;
        if (pick < 88) return $urandom_range(1, 3);
        if (pick < 96) return $urandom_range(4, 10);
        return $urandom_range(15, 30);
    endfunction

    task automatic send_request(input logic [VALUE_W-1:0] value,
                                input logic [SPACE_W-1:0] space,
                                input logic add_delim,
                                input logic [BYTE_W-1:0] delim);
        int gap;
        gap = next_gap();
        req_ch.valid         <= 1'b1;
        req_ch.value         <= value;
        req_ch.space_bytes   <= space;
        req_ch.add_delimiter <= add_delim;
        req_ch.delimiter     <= delim;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [VALUE_W-1:0] value, lo, hi;
        logic [SPACE_W-1:0] space;
        int                 pick, ndig;

        i_rst_n              <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.value         <= '0;
        req_ch.space_bytes   <= '0;
        req_ch.add_delimiter <= 1'b0;
        req_ch.delimiter     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero, space limits, digit-count boundaries and terminator choices
        send_request(32'd0,          8'd0,   1'b0, 8'h00);
        send_request(32'd0,          8'd1,   1'b1, 8'h2C);
        send_request(32'd0,          8'd2,   1'b1, 8'h2C);
        send_request(32'd9,          8'd2,   1'b0, 8'hAA);
        send_request(32'd10,         8'd2,   1'b1, 8'h3B);
        send_request(32'd10,         8'd3,   1'b1, 8'hFF);
        send_request(32'd99,         8'd3,   1'b0, 8'hFF);
        send_request(32'd100,        8'd4,   1'b1, 8'h00);
        send_request(32'd9999,       8'd5,   1'b1, 8'h0A);
        send_request(32'd10000,      8'd6,   1'b0, 8'h55);
        send_request(32'd99999999,   8'd9,   1'b1, 8'h20);
        send_request(32'd100000000,  8'd10,  1'b1, 8'h7F);
        send_request(32'd999999999,  8'd9,   1'b1, 8'h2C);
        send_request(32'd999999999,  8'd10,  1'b0, 8'h00);
        send_request(32'd1000000000, 8'd10,  1'b0, 8'h00);
        send_request(32'd1000000000, 8'd11,  1'b1, 8'h80);
        send_request(32'hFFFF_FFFF,  8'd10,  1'b1, 8'hFF);
        send_request(32'hFFFF_FFFF,  8'd11,  1'b1, 8'hFF);
        send_request(32'hFFFF_FFFF,  8'd255, 1'b0, 8'hFF);
        send_request(32'h8000_0000,  8'd255, 1'b1, 8'h01);
        send_request(32'd1234567890, 8'd11,  1'b1, 8'h2E);
        send_request(32'd7,          8'd255, 1'b1, 8'h0A);
        send_request(32'd0,          8'd255, 1'b0, 8'h33);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                value = $urandom;
            end else begin
                // uniform digit count, then a value of that length
                ndig = $urandom_range(1, NUM_DIGITS);
                lo = 1;
                repeat (ndig - 1) lo = lo * 10;
                hi = (ndig == NUM_DIGITS) ? '1 : lo * 10 - 1;
                case ($urandom_range(0, 5))
                    0: value = lo;
                    1: value = hi;
                    default: value = lo + ($urandom % (hi - lo + 1));
                endcase
            end

            ndig = 1;
            lo   = 10;
            while (ndig < NUM_DIGITS && value >= lo) begin
                ndig++;
                lo = lo * 10;
            end

            // Space mostly sits right around the digit count
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                space = SPACE_W'(ndig + $urandom_range(1, 3));
            end else if (pick < 65) begin
                space = SPACE_W'(ndig - $urandom_range(0, 1));
            end else if (pick < 85) begin
                space = SPACE_W'($urandom_range(0, 255));
            end else if (pick < 93) begin
                space = 8'hFF;
            end else begin
                space = SPACE_W'($urandom_range(0, ndig));
            end

            send_request(value, space, 1'($urandom_range(0, 1)),
                         BYTE_W'($urandom_range(0, 255)));
        end

        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/u2d_pkg.sv
sv/u2d_stream_if.sv
sv/u2d_dd_stage.sv
sv/u2d_ser.sv
sv/uint32_to_decimal_ascii.sv
tb/sv/decimal_text_monitor.sv
tb/sv/testbench.sv
